/* hw/rtl/cfe_pkg.sv */
`default_nettype none
package cfe_pkg;

    localparam int DEFAULT_COUNT_BITS = 8;
    localparam int CFG_INDEX_W        = 8;
    localparam int INDEX_W            = 9;

    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] SEP_RESET = 8'd44;

    // field_index saturates here so it never falsely matches an 8-bit select + 1
    localparam logic [INDEX_W-1:0] INDEX_SAT = 9'd257;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_SELECT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR    = 8'd1;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_QSEEN,
        MODE_TAIL,
        MODE_DEAD
    } mode_t;

    typedef struct packed {
        logic       op;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [7:0] field_count;
        logic       selected_found;
    } out_item_t;

    typedef struct packed {
        logic [7:0] field_select;
        logic [7:0] separator;
    } cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/cfe_parse_core.sv */
`default_nettype none
module cfe_parse_core #(
    parameter int COUNT_BITS = cfe_pkg::DEFAULT_COUNT_BITS
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 step,
    input  cfe_pkg::in_item_t   item,
    input  cfe_pkg::cfg_t       cfg,
    output logic                res_valid,
    output cfe_pkg::out_item_t  res
);

    localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    cfe_pkg::mode_t                  mode_reg, mode_next;
    logic [cfe_pkg::INDEX_W-1:0]     index_reg, index_next;
    logic [COUNT_BITS-1:0]           seen_reg, seen_next;
    logic                            cr_reg, cr_next;
    logic                            pending_reg, pending_next;

    logic [7:0]                      b;
    logic [CW-1:0]                   seen_wide;
    logic [cfe_pkg::INDEX_W-1:0]     sel_plus1;
    logic                            do_summary;
    logic                            do_byte;
    logic                            begin_fld;
    logic [cfe_pkg::INDEX_W-1:0]     index_eff;

    assign b         = item.in_byte;
    assign seen_wide = CW'(seen_reg);
    assign sel_plus1 = {1'b0, cfg.field_select} + 9'd1;

    always_comb
    begin
        mode_next    = mode_reg;
        index_next   = index_reg;
        seen_next    = seen_reg;
        cr_next      = cr_reg;
        pending_next = pending_reg;
        do_summary   = 1'b0;
        do_byte      = 1'b0;
        begin_fld    = 1'b0;

        if (item.op == cfe_pkg::OP_END)
        begin
            cr_next    = 1'b0;
            do_summary = pending_reg;
            mode_next    = cfe_pkg::MODE_START;
            index_next   = '0;
            seen_next    = '0;
            pending_next = 1'b0;
        end
        else if (cr_reg && b == cfe_pkg::CH_LF)
        begin
            // LF of a CR LF pair: swallowed
            cr_next = 1'b0;
        end
        else if (b == cfe_pkg::CH_CR || b == cfe_pkg::CH_LF)
        begin
            cr_next      = (b == cfe_pkg::CH_CR);
            do_summary   = 1'b1;
            mode_next    = cfe_pkg::MODE_START;
            index_next   = '0;
            seen_next    = '0;
            pending_next = 1'b0;
        end
        else
        begin
            cr_next      = 1'b0;
            pending_next = 1'b1;
            if (mode_reg == cfe_pkg::MODE_DEAD)
            begin
                mode_next = cfe_pkg::MODE_DEAD;
            end
            else if (b == cfe_pkg::CH_NUL)
            begin
                mode_next = cfe_pkg::MODE_DEAD;
            end
            else
            begin
                unique case (mode_reg) inside
                    cfe_pkg::MODE_START:
                    begin
                        begin_fld = 1'b1;
                        if (b == cfe_pkg::CH_QUOTE)
                            mode_next = cfe_pkg::MODE_QUOTED;
                        else if (b != cfg.separator)
                        begin
                            mode_next = cfe_pkg::MODE_PLAIN;
                            do_byte   = 1'b1;
                        end
                    end
                    cfe_pkg::MODE_PLAIN, cfe_pkg::MODE_TAIL:
                    begin
                        if (b == cfg.separator)
                            mode_next = cfe_pkg::MODE_START;
                        else
                            do_byte = 1'b1;
                    end
                    cfe_pkg::MODE_QUOTED:
                    begin
                        if (b == cfe_pkg::CH_QUOTE)
                            mode_next = cfe_pkg::MODE_QSEEN;
                        else
                            do_byte = 1'b1;
                    end
                    cfe_pkg::MODE_QSEEN:
                    begin
                        if (b == cfe_pkg::CH_QUOTE)
                        begin
                            mode_next = cfe_pkg::MODE_QUOTED;
                            do_byte   = 1'b1;
                        end
                        else if (b == cfg.separator)
                            mode_next = cfe_pkg::MODE_START;
                        else
                        begin
                            mode_next = cfe_pkg::MODE_TAIL;
                            do_byte   = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = cfe_pkg::MODE_DEAD;
                    end
                endcase
                if (begin_fld)
                begin
                    if (index_reg < cfe_pkg::INDEX_SAT)
                        index_next = index_reg + 9'd1;
                    if (seen_reg < COUNT_MAX)
                        seen_next = seen_reg + 1'b1;
                end
            end
        end

        // byte output compares against the index after any field start
        index_eff = begin_fld ? index_next : index_reg;

        res       = '0;
        res_valid = 1'b0;
        if (do_summary)
        begin
            res_valid          = 1'b1;
            res.kind           = cfe_pkg::KIND_SUMMARY;
            res.field_count    = (seen_wide > CW'(255)) ? 8'hFF : seen_wide[7:0];
            res.selected_found = (cfg.field_select == 8'd0) ||
                                 (index_reg > {1'b0, cfg.field_select});
        end
        else if (do_byte && index_eff == sel_plus1)
        begin
            res_valid    = 1'b1;
            res.kind     = cfe_pkg::KIND_BYTE;
            res.out_byte = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= cfe_pkg::MODE_START;
            index_reg   <= '0;
            seen_reg    <= '0;
            cr_reg      <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            index_reg   <= index_next;
            seen_reg    <= seen_next;
            cr_reg      <= cr_next;
            pending_reg <= pending_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/cfe_out_stage.sv */
`default_nettype none
module cfe_out_stage (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 load,
    input  cfe_pkg::out_item_t  load_item,
    output logic                can_take,
    output logic                out_valid,
    input  wire                 out_ready,
    output cfe_pkg::out_item_t  out_item
);

    logic               valid_reg, valid_next;
    cfe_pkg::out_item_t item_reg;

    // free now, or the waiting result leaves on this edge
    assign can_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= load_item;
    end

endmodule
`default_nettype wire

/* hw/rtl/csv_field_extractor.sv */
`default_nettype none
// CSV field extractor. Takes one character (or end-of-input marker) per clock
// and returns the content bytes of the field chosen by field_select, plus a
// summary item at each line end (CR, LF or CR LF) and at end of input with a
// line pending. Throughput is one item per cycle. An item is held in the input
// register; its result, if any, is registered in the output stage and offered
// on the output, and can transfer at the next edge at the earliest, with the
// parse step itself combinational logic between the two registers.
// Backpressure on the result side stalls every parse step, even one with no
// result, and, once the input register is full, the input channel. No clearing
// pass after reset. Configuration writes are taken every cycle and should be
// made while idle.
module csv_field_extractor #(
    parameter int COUNT_BITS = cfe_pkg::DEFAULT_COUNT_BITS
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  cfe_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  wire                               out_ready,
    output cfe_pkg::out_item_t                out_item,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [cfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [7:0]                         cfg_data
);

    cfe_pkg::cfg_t       cfg_reg;
    logic                in_valid_reg, in_valid_next;
    cfe_pkg::in_item_t   in_item_reg;
    logic                core_step;
    logic                res_valid;
    cfe_pkg::out_item_t  res;
    logic                out_can_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_select <= 8'd0;
            cfg_reg.separator    <= cfe_pkg::SEP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cfe_pkg::REG_FIELD_SELECT: cfg_reg.field_select <= cfg_data;
                cfe_pkg::REG_SEPARATOR:    cfg_reg.separator    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign core_step = in_valid_reg && out_can_take;
    assign in_ready  = !in_valid_reg || core_step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (core_step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
    end

    cfe_parse_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (core_step),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    cfe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (core_step && res_valid),
        .load_item (res),
        .can_take  (out_can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // an empty input register always takes a transfer
    a_in_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input register empty but not ready");

    // a new result only comes from a parse step that produced one
    a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(core_step && res_valid))
        else $error("result appeared without a parse step");

    // summaries carry no content byte, content bytes carry no count
    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.kind == cfe_pkg::KIND_SUMMARY && out_item.out_byte == 8'd0)
                    || (out_item.kind == cfe_pkg::KIND_BYTE && out_item.field_count == 8'd0
                        && !out_item.selected_found)))
        else $error("result fields inconsistent with kind");

endmodule
`default_nettype wire

/* test/csv_field_extractor_tb.sv */
`timescale 1ns / 100ps

module csv_field_extractor_tb;

    localparam int COUNT_BITS  = cfe_pkg::DEFAULT_COUNT_BITS;
    localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
    localparam int SETTLE      = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_TARGET = 1850;
    localparam int PHASE_ITEMS = 170;
    localparam int MAX_REPORTS = 10;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    cfe_pkg::in_item_t               in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    cfe_pkg::out_item_t              out_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [cfe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]                      cfg_data  = '0;

    // parser shadow state
    cfe_pkg::mode_t     pmode;
    int unsigned        field_idx;
    int unsigned        field_cnt;
    bit                 cr_mark;
    bit                 line_open;
    logic [7:0]         sel_field;
    logic [7:0]         sep_char;
    cfe_pkg::out_item_t pending_results[$];

    int items_sent      = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int mismatches      = 0;
    bit gaps_on         = 1'b1;
    bit stalls_on       = 1'b1;
    bit hold_req        = 1'b0;
    bit hold_active     = 1'b0;

    csv_field_extractor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void clear_line_state();
        pmode     = cfe_pkg::MODE_START;
        field_idx = 0;
        field_cnt = 0;
        line_open = 1'b0;
    endfunction

    function automatic bit line_summary(output cfe_pkg::out_item_t res);
        res                = '0;
        res.kind           = cfe_pkg::KIND_SUMMARY;
        res.field_count    = (field_cnt > 255) ? 8'd255 : 8'(field_cnt);
        res.selected_found = (sel_field == 8'd0) || (field_idx > sel_field);
        clear_line_state();
        return 1'b1;
    endfunction

    function automatic bit field_byte(input logic [7:0] b, output cfe_pkg::out_item_t res);
        res = '0;
        if (field_idx != sel_field + 1)
            return 1'b0;
        res.kind     = cfe_pkg::KIND_BYTE;
        res.out_byte = b;
        return 1'b1;
    endfunction

    // one parse step; returns 1 when the item yields a result
    function automatic bit parse_item(input cfe_pkg::in_item_t it,
                                      output cfe_pkg::out_item_t res);
        logic [7:0] b;
        b   = it.in_byte;
        res = '0;
        if (it.op == cfe_pkg::OP_END)
        begin
            cr_mark = 1'b0;
            if (line_open)
                return line_summary(res);
            clear_line_state();
            return 1'b0;
        end
        if (cr_mark)
        begin
            cr_mark = 1'b0;
            if (b == cfe_pkg::CH_LF)
                return 1'b0;
        end
        if (b == cfe_pkg::CH_CR || b == cfe_pkg::CH_LF)
        begin
            cr_mark = (b == cfe_pkg::CH_CR);
            return line_summary(res);
        end
        line_open = 1'b1;
        if (pmode == cfe_pkg::MODE_DEAD)
            return 1'b0;
        if (b == cfe_pkg::CH_NUL)
        begin
            pmode = cfe_pkg::MODE_DEAD;
            return 1'b0;
        end
        case (pmode) inside
            cfe_pkg::MODE_START:
            begin
                if (field_idx < cfe_pkg::INDEX_SAT)
                    field_idx++;
                if (field_cnt < COUNT_MAX)
                    field_cnt++;
                if (b == cfe_pkg::CH_QUOTE)
                begin
                    pmode = cfe_pkg::MODE_QUOTED;
                    return 1'b0;
                end
                if (b == sep_char)
                    return 1'b0;
                pmode = cfe_pkg::MODE_PLAIN;
                return field_byte(b, res);
            end
            cfe_pkg::MODE_PLAIN, cfe_pkg::MODE_TAIL:
            begin
                if (b == sep_char)
                begin
                    pmode = cfe_pkg::MODE_START;
                    return 1'b0;
                end
                return field_byte(b, res);
            end
            cfe_pkg::MODE_QUOTED:
            begin
                if (b == cfe_pkg::CH_QUOTE)
                begin
                    pmode = cfe_pkg::MODE_QSEEN;
                    return 1'b0;
                end
                return field_byte(b, res);
            end
            cfe_pkg::MODE_QSEEN:
            begin
                if (b == cfe_pkg::CH_QUOTE)
                begin
                    pmode = cfe_pkg::MODE_QUOTED;
                    return field_byte(b, res);
                end
                if (b == sep_char)
                begin
                    pmode = cfe_pkg::MODE_START;
                    return 1'b0;
                end
                pmode = cfe_pkg::MODE_TAIL;
                return field_byte(b, res);
            end
            default:
            begin
                pmode = cfe_pkg::MODE_DEAD;
                return 1'b0;
            end
        endcase
    endfunction

    // predicts on input transfers, checks on output transfers
    always @(posedge clk)
    begin : monitor
        cfe_pkg::out_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                case (cfg_index)
                    cfe_pkg::REG_FIELD_SELECT: sel_field = cfg_data;
                    cfe_pkg::REG_SEPARATOR:    sep_char  = cfg_data;
                    default:                   ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                items_sent++;
                if (parse_item(in_item, want))
                    pending_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result kind=%0d byte=%02h count=%0d found=%0d",
                                 $time, out_item.kind, out_item.out_byte,
                                 out_item.field_count, out_item.selected_found);
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (out_item.kind !== want.kind || out_item.out_byte !== want.out_byte ||
                        out_item.field_count !== want.field_count ||
                        out_item.selected_found !== want.selected_found)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: mismatch, expected kind=%0d byte=%02h count=%0d ",
                                      "found=%0d, got kind=%0d byte=%02h count=%0d found=%0d"},
                                     $time, want.kind, want.out_byte, want.field_count,
                                     want.selected_found, out_item.kind, out_item.out_byte,
                                     out_item.field_count, out_item.selected_found);
                    end
                end
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : receiver
        int len;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_active = 1'b1;
                out_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end
            else if (!stalls_on || $urandom_range(0, 99) < 65)
            begin
                out_ready <= 1'b1;
                len = stalls_on ? $urandom_range(1, 10) : 1;
                repeat (len) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // called at a clock edge; returns at the edge of the transfer with valid still high
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {op, (op == cfe_pkg::OP_END) ? 8'($urandom) : b};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(cfe_pkg::OP_BYTE, s[i]);
    endtask

    task automatic quiet_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        quiet_input();
        while (pending_results.size() != 0) @(posedge clk);
        // items with no result may still be in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cfe_pkg::CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] sel, input logic [7:0] sep);
        write_reg(cfe_pkg::REG_FIELD_SELECT, sel);
        write_reg(cfe_pkg::REG_SEPARATOR, sep);
    endtask

    function automatic logic [7:0] text_byte(input bit quoted);
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == cfe_pkg::CH_CR || b == cfe_pkg::CH_LF || b == cfe_pkg::CH_QUOTE ||
               (!quoted && b == sep_char))
            b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    // a well-formed line with random content, now and then a stray byte or end of input
    task automatic send_line();
        int n_fields;
        int r;
        n_fields = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f > 0)
                send_item(cfe_pkg::OP_BYTE, sep_char);
            if ($urandom_range(0, 99) < 30)
            begin
                send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_QUOTE);
                        send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_QUOTE);
                    end
                    else
                        send_item(cfe_pkg::OP_BYTE, text_byte(1'b1));
                end
                send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_QUOTE);
                if ($urandom_range(0, 4) == 0)
                    send_item(cfe_pkg::OP_BYTE, text_byte(1'b0));
            end
            else
            begin
                repeat ($urandom_range(0, 5))
                    send_item(cfe_pkg::OP_BYTE, text_byte(1'b0));
            end
            if ($urandom_range(0, 19) == 0)
                send_item(cfe_pkg::OP_BYTE, 8'($urandom));
        end
        if ($urandom_range(0, 7) == 0)
            send_item(cfe_pkg::OP_BYTE, sep_char);
        if ($urandom_range(0, 49) == 0)
            send_item(cfe_pkg::OP_END, 8'h00);
        r = $urandom_range(0, 9);
        if (r < 4)
            send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_LF);
        else if (r < 7)
            send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_CR);
        else if (r < 9)
        begin
            send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_CR);
            send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_LF);
        end
        else
            send_item(cfe_pkg::OP_END, 8'h00);
    endtask

    // reset config: field 0, comma separator
    task automatic test_default_config();
        send_text("a,b,\r\n");
        send_text("\n");
        send_item(cfe_pkg::OP_END, 8'h00);
        send_item(cfe_pkg::OP_BYTE, 8'hFF);
        send_item(cfe_pkg::OP_END, 8'h00);
    endtask

    task automatic test_quoted_fields();
        send_text("\"x\"\"y\"z,w\r");
        // end of input drops the CR mark, so the LF is an empty line
        send_item(cfe_pkg::OP_END, 8'h00);
        send_text("\n");
        send_text("p");
        send_item(cfe_pkg::OP_BYTE, cfe_pkg::CH_NUL);
        send_text("q\n");
    endtask

    task automatic test_output_hold();
        bit saved;
        saved    = gaps_on;
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        quiet_input();
        while (!hold_active) @(posedge clk);
        repeat (8) send_line();
        gaps_on = saved;
    endtask

    task automatic test_count_saturation();
        configure(8'd255, cfe_pkg::SEP_RESET);
        repeat (255) send_item(cfe_pkg::OP_BYTE, sep_char);
        send_text("x");
        repeat (10) send_text(",y");
        send_text("\n");
        send_text("a,b\n");
    endtask

    task automatic test_random_lines();
        logic [7:0] sep_list [8];
        logic [7:0] sel;
        int         p;
        int         phase_end;
        sep_list = '{cfe_pkg::SEP_RESET, 8'h09, cfe_pkg::CH_QUOTE, cfe_pkg::CH_NUL,
                     cfe_pkg::CH_CR, cfe_pkg::CH_LF, 8'hFF, 8'h3B};
        p = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (p % 5)
                0:       sel = 8'd0;
                1:       sel = 8'd1;
                2:       sel = 8'd2;
                3:       sel = 8'd255;
                default: sel = 8'($urandom_range(0, 4));
            endcase
            configure(sel, (p < 8) ? sep_list[p] : 8'($urandom));
            gaps_on   = (p % 3) != 1;
            stalls_on = (p % 3) != 2;
            phase_end = (items_sent + PHASE_ITEMS < ITEM_TARGET) ?
                        items_sent + PHASE_ITEMS : ITEM_TARGET;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_line();
                else
                begin
                    repeat ($urandom_range(1, 8))
                        send_item(($urandom_range(0, 15) == 0) ?
                                  cfe_pkg::OP_END : cfe_pkg::OP_BYTE,
                                  8'($urandom));
                end
            end
            p++;
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin : main
        sel_field = 8'd0;
        sep_char  = cfe_pkg::SEP_RESET;
        cr_mark   = 1'b0;
        clear_line_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_config();
        test_quoted_fields();
        test_output_hold();
        test_count_saturation();
        test_random_lines();

        wait_idle();
        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end
        $display("run covered %0d input transfers, %0d results checked, %0d register writes",
                 items_sent, results_checked, cfg_writes);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/cfe_pkg.sv
hw/rtl/cfe_parse_core.sv
hw/rtl/cfe_out_stage.sv
hw/rtl/csv_field_extractor.sv
test/csv_field_extractor_tb.sv
